// ===== hdl/rps_pkg.sv =====
// Shared types and constants for the readout packet sequencer.
`default_nettype none

package rps_pkg;

    localparam logic [7:0]  STATUS_TEMP   = 8'hA0;
    localparam logic [7:0]  STATUS_TS     = 8'h08;
    localparam int unsigned DATA_FLAG_BIT = 6;
    localparam logic [31:0] TAG_TEMP      = 32'h41437A00;
    localparam logic [31:0] TAG_TS        = 32'h454D4954;
    localparam logic [31:0] TAG_DATA      = 32'h41434841;

    localparam logic [7:0]  REC_START     = 8'h01;
    localparam logic [7:0]  REC_STOP      = 8'h02;
    localparam logic [7:0]  REC_TRIGGER   = 8'h10;

    localparam logic [31:0] CYCLE_RESET   = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CLASS_TEMP     = 3'd0,
        CLASS_TS       = 3'd1,
        CLASS_DROPPED  = 3'd2,
        CLASS_DATA     = 3'd3,
        CLASS_BAD_HDR  = 3'd4,
        CLASS_NO_EVENT = 3'd5
    } packet_class_t;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic [31:0] tag_word;
        logic [7:0]  record_type;
        logic [15:0] raw_trigger_id;
        logic [7:0]  lda_cycle;
        logic [47:0] timestamp;
    } in_item_t;

    typedef struct packed {
        packet_class_t      packet_class;
        logic               new_event;
        logic signed [31:0] event_cycle;
        logic [15:0]        missed_triggers;
        logic               trigger_validated;
        logic               outside_acq;
        logic               acq_active;
        logic               ts_block_ready;
        logic [47:0]        start_ts;
        logic [47:0]        stop_ts;
        logic [47:0]        trig_ts;
    } out_item_t;

    typedef struct packed {
        logic [31:0] cycle_count;
        logic [15:0] trigger_count;
        logic        inside_acq;
        logic        event_open;
        logic [47:0] start_stamp;
        logic [47:0] stop_stamp;
        logic [47:0] trigger_stamp;
    } seq_state_t;

endpackage

`default_nettype wire

// ===== hdl/readout_packet_sequencer_unit.sv =====
// Top level of the readout packet sequencer: input register, core, result register.
// A packet held in the input register is classified combinationally by the core and then
// registered into the result register, which drives m_valid.
// Throughput: one packet per cycle while m_ready stays high; the input register advances
// whenever the result register is empty or being taken, so m_ready feeds s_ready directly.
// Reset (aresetn low, synchronous): both stages empty, cycle count -1,
// trigger count 0, acquisition off, no event open, captured timestamps zero.
`default_nettype none

module readout_packet_sequencer_unit (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire rps_pkg::in_item_t s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output rps_pkg::out_item_t m_data
);

    rps_pkg::in_item_t   in_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    rps_pkg::out_item_t  out_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    rps_pkg::seq_state_t state_reg;
    rps_pkg::seq_state_t state_next;
    rps_pkg::out_item_t  core_result;
    logic                advance;
    logic                in_xfer;

    rps_core u_core (
        .item       (in_reg),
        .state      (state_reg),
        .result     (core_result),
        .state_next (state_next)
    );

    always_comb begin
        advance        = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready        = !in_valid_reg || advance;
        in_xfer        = s_valid && s_ready;
        in_valid_next  = in_xfer || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{cycle_count:   rps_pkg::CYCLE_RESET,
                               trigger_count: 16'd0,
                               inside_acq:    1'b0,
                               event_open:    1'b0,
                               start_stamp:   48'd0,
                               stop_stamp:    48'd0,
                               trigger_stamp: 48'd0};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // released stamps only ever ride on a good data header
    a_release_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.ts_block_ready) |->
            (m_data.packet_class == rps_pkg::CLASS_DATA
             || m_data.packet_class == rps_pkg::CLASS_NO_EVENT))
        else $error("timestamps released on a non-data packet");

    // trigger status only on handled timestamp records
    a_trig_is_ts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.trigger_validated || m_data.outside_acq
                     || m_data.missed_triggers != 16'd0)) |->
            (m_data.packet_class == rps_pkg::CLASS_TS && m_data.trigger_validated))
        else $error("trigger status outside a trigger record");

    // a trigger outside acquisition or with skipped ids always opens an event
    a_forced_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.outside_acq || m_data.missed_triggers != 16'd0)) |->
            m_data.new_event)
        else $error("forced event not flagged");

    // a result register that is stalled keeps the sequencer state frozen
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(state_reg))
        else $error("state changed while output stalled");

endmodule

`default_nettype wire

// ===== hdl/rps_core.sv =====
// Packet classification and sequencer state update for one packet.
`default_nettype none

module rps_core (
    input  wire rps_pkg::in_item_t   item,
    input  wire rps_pkg::seq_state_t state,
    output rps_pkg::out_item_t       result,
    output rps_pkg::seq_state_t      state_next
);

    logic        is_temp;
    logic        is_ts;
    logic        rec_known;
    logic        is_trig;
    logic [15:0] missed;
    logic        forced;
    logic        open_mid;
    logic [7:0]  cyc_eff;
    logic        open_new;
    logic        stamps_full;

    always_comb begin
        is_temp   = (item.status_byte == rps_pkg::STATUS_TEMP)
                 && (item.tag_word == rps_pkg::TAG_TEMP);
        is_ts     = (item.status_byte == rps_pkg::STATUS_TS)
                 && (item.tag_word == rps_pkg::TAG_TS);
        rec_known = (item.record_type == rps_pkg::REC_START)
                 || (item.record_type == rps_pkg::REC_STOP)
                 || (item.record_type == rps_pkg::REC_TRIGGER);
        is_trig   = (item.record_type == rps_pkg::REC_TRIGGER);

        missed    = item.raw_trigger_id - state.trigger_count - 16'd1;
        forced    = is_trig && !state.inside_acq;
        open_mid  = state.event_open || (is_trig && (missed != 16'd0));
        cyc_eff   = forced ? (item.lda_cycle - 8'd1) : item.lda_cycle;
        open_new  = !open_mid || (state.cycle_count[7:0] != cyc_eff) || forced;

        stamps_full = (state.start_stamp[31:0] != 32'd0)
                   && (state.stop_stamp[31:0] != 32'd0)
                   && (state.trigger_stamp[31:0] != 32'd0);

        state_next = state;
        result     = '0;

        priority if (is_ts && rec_known) begin
            result.packet_class = rps_pkg::CLASS_TS;
            if (open_new && !forced) begin
                state_next.cycle_count = state.cycle_count + 32'd1;
            end
            state_next.event_open = open_mid || open_new;
            result.new_event      = open_new || (is_trig && (missed != 16'd0));
            unique case (item.record_type)
                rps_pkg::REC_START: begin
                    state_next.start_stamp = item.timestamp;
                    state_next.inside_acq  = 1'b1;
                end
                rps_pkg::REC_STOP: begin
                    state_next.stop_stamp = item.timestamp;
                    state_next.inside_acq = 1'b0;
                end
                default: begin
                    // counter jumps to id - 1, then counts this trigger
                    state_next.trigger_stamp  = item.timestamp;
                    state_next.trigger_count  = item.raw_trigger_id;
                    result.missed_triggers    = missed;
                    result.trigger_validated  = 1'b1;
                    result.outside_acq        = forced;
                end
            endcase
        end else if (is_temp) begin
            result.packet_class = rps_pkg::CLASS_TEMP;
        end else if (!item.status_byte[rps_pkg::DATA_FLAG_BIT]) begin
            result.packet_class = rps_pkg::CLASS_DROPPED;
        end else if (item.tag_word != rps_pkg::TAG_DATA) begin
            result.packet_class = rps_pkg::CLASS_BAD_HDR;
        end else begin
            result.packet_class = state.event_open ? rps_pkg::CLASS_DATA
                                                   : rps_pkg::CLASS_NO_EVENT;
            if (stamps_full) begin
                result.ts_block_ready    = 1'b1;
                result.start_ts          = state.start_stamp;
                result.stop_ts           = state.stop_stamp;
                result.trig_ts           = state.trigger_stamp;
                state_next.start_stamp   = '0;
                state_next.stop_stamp    = '0;
                state_next.trigger_stamp = '0;
            end
        end

        result.event_cycle = $signed(state_next.cycle_count);
        result.acq_active  = state_next.inside_acq;
    end

endmodule

`default_nettype wire

// ===== test/readout_packet_sequencer_unit_test.sv =====
// Testbench for the readout packet sequencer: directed and random packets against a scoreboard.
`timescale 1ns / 100ps

module readout_packet_sequencer_unit_test;

    // Mirrors the sequencer state and keeps the outcome of each accepted packet in order.
    class sequencer_scoreboard;
        logic [31:0]        cyc_cnt;
        logic [15:0]        trig_cnt;
        logic               in_acq;
        logic               ev_open;
        logic [47:0]        start_stamp;
        logic [47:0]        stop_stamp;
        logic [47:0]        trig_stamp;
        rps_pkg::out_item_t outcome_buf[2048];
        int                 wr_cnt;
        int                 rd_cnt;
        int                 fails;

        function new();
            cyc_cnt     = rps_pkg::CYCLE_RESET;
            trig_cnt    = '0;
            in_acq      = 1'b0;
            ev_open     = 1'b0;
            start_stamp = '0;
            stop_stamp  = '0;
            trig_stamp  = '0;
            wr_cnt      = 0;
            rd_cnt      = 0;
            fails       = 0;
        endfunction

        function int pending();
            return wr_cnt - rd_cnt;
        endfunction

        function void record_packet(rps_pkg::in_item_t it);
            rps_pkg::out_item_t r;
            logic [7:0]         cyc;
            logic               forced;
            logic               is_temp;
            logic               is_ts;
            r       = '0;
            cyc     = it.lda_cycle;
            forced  = 1'b0;
            is_temp = (it.status_byte == rps_pkg::STATUS_TEMP)
                   && (it.tag_word == rps_pkg::TAG_TEMP);
            is_ts   = (it.status_byte == rps_pkg::STATUS_TS)
                   && (it.tag_word == rps_pkg::TAG_TS);
            if (is_ts && (it.record_type == rps_pkg::REC_START
                          || it.record_type == rps_pkg::REC_STOP
                          || it.record_type == rps_pkg::REC_TRIGGER)) begin
                r.packet_class = rps_pkg::CLASS_TS;
                if (it.record_type == rps_pkg::REC_TRIGGER) begin
                    r.missed_triggers = it.raw_trigger_id - trig_cnt - 16'd1;
                    if (r.missed_triggers != 16'd0) begin
                        ev_open     = 1'b1;
                        r.new_event = 1'b1;
                    end
                    trig_cnt = it.raw_trigger_id - 16'd1;
                    if (!in_acq) begin
                        r.outside_acq = 1'b1;
                        forced        = 1'b1;
                        cyc           = cyc - 8'd1;
                    end
                end
                if (!ev_open || cyc_cnt[7:0] != cyc || forced) begin
                    if (!forced)
                        cyc_cnt = cyc_cnt + 32'd1;
                    ev_open     = 1'b1;
                    r.new_event = 1'b1;
                end
                if (it.record_type == rps_pkg::REC_START) begin
                    start_stamp = it.timestamp;
                    in_acq      = 1'b1;
                end else if (it.record_type == rps_pkg::REC_STOP) begin
                    stop_stamp = it.timestamp;
                    in_acq     = 1'b0;
                end else begin
                    trig_stamp          = it.timestamp;
                    r.trigger_validated = 1'b1;
                    trig_cnt            = trig_cnt + 16'd1;
                end
            end else if (is_temp) begin
                r.packet_class = rps_pkg::CLASS_TEMP;
            end else if (!it.status_byte[rps_pkg::DATA_FLAG_BIT]) begin
                r.packet_class = rps_pkg::CLASS_DROPPED;
            end else if (it.tag_word != rps_pkg::TAG_DATA) begin
                r.packet_class = rps_pkg::CLASS_BAD_HDR;
            end else begin
                // only the low 32 bits decide the release, all 48 go out
                if (start_stamp[31:0] != 0 && stop_stamp[31:0] != 0 && trig_stamp[31:0] != 0) begin
                    r.ts_block_ready = 1'b1;
                    r.start_ts       = start_stamp;
                    r.stop_ts        = stop_stamp;
                    r.trig_ts        = trig_stamp;
                    start_stamp      = '0;
                    stop_stamp       = '0;
                    trig_stamp       = '0;
                end
                r.packet_class = ev_open ? rps_pkg::CLASS_DATA : rps_pkg::CLASS_NO_EVENT;
            end
            r.event_cycle = cyc_cnt;
            r.acq_active  = in_acq;
            outcome_buf[wr_cnt % 2048] = r;
            wr_cnt++;
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                fails++;
            end
        endfunction

        function void check_result(rps_pkg::out_item_t got);
            rps_pkg::out_item_t want;
            if (wr_cnt == rd_cnt) begin
                $display("%0t: unexpected result: expected none, actual %0h", $time, got);
                fails++;
                return;
            end
            want = outcome_buf[rd_cnt % 2048];
            rd_cnt++;
            check_field("packet_class", want.packet_class, got.packet_class);
            check_field("new_event", want.new_event, got.new_event);
            check_field("event_cycle", want.event_cycle, got.event_cycle);
            check_field("missed_triggers", want.missed_triggers, got.missed_triggers);
            check_field("trigger_validated", want.trigger_validated, got.trigger_validated);
            check_field("outside_acq", want.outside_acq, got.outside_acq);
            check_field("acq_active", want.acq_active, got.acq_active);
            check_field("ts_block_ready", want.ts_block_ready, got.ts_block_ready);
            check_field("start_ts", want.start_ts, got.start_ts);
            check_field("stop_ts", want.stop_ts, got.stop_ts);
            check_field("trig_ts", want.trig_ts, got.trig_ts);
        endfunction
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    rps_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    rps_pkg::out_item_t m_data;

    sequencer_scoreboard sb;
    bit tx_calm;
    bit rx_calm;

    readout_packet_sequencer_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [47:0] rand_stamp();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    function automatic rps_pkg::in_item_t pkt(logic [7:0] st, logic [31:0] tag,
                                              logic [7:0] rt, logic [15:0] rid,
                                              logic [7:0] cyc, logic [47:0] ts);
        rps_pkg::in_item_t it;
        it.status_byte    = st;
        it.tag_word       = tag;
        it.record_type    = rt;
        it.raw_trigger_id = rid;
        it.lda_cycle      = cyc;
        it.timestamp      = ts;
        return it;
    endfunction

    // Mostly well-formed timestamp and data traffic that follows the tracked
    // cycle and trigger id, plus near misses and pure noise.
    function automatic rps_pkg::in_item_t rand_packet();
        rps_pkg::in_item_t it;
        int                kind;
        int                sel;
        it.status_byte    = 8'($urandom);
        it.tag_word       = $urandom;
        it.record_type    = 8'($urandom);
        it.raw_trigger_id = 16'($urandom);
        it.lda_cycle      = 8'($urandom);
        it.timestamp      = rand_stamp();
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            it.status_byte = rps_pkg::STATUS_TS;
            it.tag_word    = rps_pkg::TAG_TS;
            sel = $urandom_range(0, 9);
            if (sel < 2)      it.record_type = rps_pkg::REC_START;
            else if (sel < 4) it.record_type = rps_pkg::REC_STOP;
            else if (sel < 9) it.record_type = rps_pkg::REC_TRIGGER;
            sel = $urandom_range(0, 7);
            if (sel < 5)       it.raw_trigger_id = sb.trig_cnt + 16'd1;
            else if (sel == 5) it.raw_trigger_id = sb.trig_cnt + 16'($urandom_range(2, 4));
            else if (sel == 6) it.raw_trigger_id = sb.trig_cnt;
            sel = $urandom_range(0, 5);
            if (sel < 3)       it.lda_cycle = sb.cyc_cnt[7:0];
            else if (sel == 3) it.lda_cycle = sb.cyc_cnt[7:0] + 8'd1;
            else if (sel == 4) it.lda_cycle = sb.cyc_cnt[7:0] - 8'd1;
            sel = $urandom_range(0, 9);
            if (sel == 0)      it.timestamp = '0;
            else if (sel == 1) it.timestamp[31:0] = '0;
        end else if (kind < 70) begin
            it.status_byte[rps_pkg::DATA_FLAG_BIT] = 1'b1;
            if ($urandom_range(0, 7) != 0)
                it.tag_word = rps_pkg::TAG_DATA;
        end else if (kind < 78) begin
            it.status_byte = rps_pkg::STATUS_TEMP;
            it.tag_word    = rps_pkg::TAG_TEMP;
        end else if (kind < 90) begin
            // known or random status with a mismatched or matching tag
            case ($urandom_range(0, 3))
                0: it.status_byte = rps_pkg::STATUS_TS;
                1: it.status_byte = rps_pkg::STATUS_TEMP;
                2: it.status_byte = rps_pkg::STATUS_TS | 8'h40;
                default: ;
            endcase
            case ($urandom_range(0, 3))
                0: it.tag_word = rps_pkg::TAG_TS;
                1: it.tag_word = rps_pkg::TAG_TEMP;
                2: it.tag_word = rps_pkg::TAG_DATA;
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic send_packet(input rps_pkg::in_item_t it);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.record_packet(it);
    endtask

    // result side: random stalls, then wait for a transfer
    initial begin
        int stall;
        int taken;
        taken = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (taken % 50 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            stall = rx_calm ? 0 : $urandom_range(0, 10);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_data);
            taken++;
        end
    end

    initial begin
        sb = new();
        tx_calm = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part
        send_packet(pkt(rps_pkg::STATUS_TEMP, rps_pkg::TAG_TEMP, 8'h00, 16'h0000, 8'h00,
                        48'h0));
        send_packet(pkt(8'h40, rps_pkg::TAG_DATA, 8'h00, 16'h0000, 8'h00, 48'h0)); // no event yet
        send_packet(pkt(8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF));
        send_packet(pkt(8'h00, 32'h0, 8'h00, 16'h0000, 8'h00, 48'h0));
        // unknown record
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, 8'hFF, 16'h0001, 8'h00, 48'h1));
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, 8'h00, 16'h0001, 8'h00, 48'h1));
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_TRIGGER, 16'h0001,
                        8'h00, 48'hFFFF_FFFF_FFFF));
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_START, 16'h0000,
                        8'h00, 48'hFFFF_FFFF_FFFF));
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_TRIGGER, 16'h0002,
                        8'h00, 48'h1));
        // skipped ids
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_TRIGGER, 16'h000A,
                        8'h00, 48'h2));
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_STOP, 16'h0000,
                        8'h00, 48'h0000_1234_5678));
        send_packet(pkt(8'h40, rps_pkg::TAG_DATA, 8'h00, 16'h0000, 8'h00, 48'h0)); // release
        send_packet(pkt(8'hFF, rps_pkg::TAG_DATA, 8'hFF, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF));
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_START, 16'h0000,
                        8'h01, 48'hFFFF_0000_0000));
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_TRIGGER, 16'h0000,
                        8'h01, 48'h8000_0000_0001));
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_STOP, 16'hFFFF,
                        8'hFF, 48'hFFFF_FFFF_FFFF));
        // start low half zero
        send_packet(pkt(8'h40, rps_pkg::TAG_DATA, 8'h00, 16'h0000, 8'h00, 48'h0));
        // outside acq
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_TRIGGER, 16'hFFFF,
                        8'hFF, 48'h0));
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_START, 16'h0000,
                        8'h00, 48'h0));
        // cycle change
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_TRIGGER, 16'h0000,
                        8'h7F, 48'h5));
        send_packet(pkt(8'h4F, rps_pkg::TAG_DATA, 8'h00, 16'h0000, 8'h00, 48'h0));
        send_packet(pkt(rps_pkg::STATUS_TEMP, rps_pkg::TAG_TS, 8'h00, 16'h0000, 8'h00, 48'h0));
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TEMP, rps_pkg::REC_START, 16'h0000,
                        8'h00, 48'h0));
        send_packet(pkt(rps_pkg::STATUS_TS | 8'h40, rps_pkg::TAG_TS, rps_pkg::REC_STOP,
                        16'h0000, 8'h00, 48'h0));
        send_packet(pkt(rps_pkg::STATUS_TS, rps_pkg::TAG_TS, rps_pkg::REC_STOP, 16'h0000,
                        8'h80, 48'h0000_0001_0000));

        // random part
        for (int n = 0; n < 1150; n++) begin
            if (n % 50 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            send_packet(rand_packet());
        end
        @(negedge aclk);
        s_valid = 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
